// File: src/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants for the lottery scheduler pick unit.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // result kinds chosen by the controller
  localparam logic [2:0] RES_ADD   = 3'd0;
  localparam logic [2:0] RES_FULL  = 3'd1;
  localparam logic [2:0] RES_EMPTY = 3'd2;
  localparam logic [2:0] RES_WIN   = 3'd3;
  localparam logic [2:0] RES_NONE  = 3'd4;

  // field widths
  localparam int ID_W    = 8;
  localparam int CNT_W   = 16;
  localparam int WGT_W   = 15;
  localparam int RND_W   = 31;
  localparam int TOT_W   = 19;
  localparam int ENT_W   = ID_W + WGT_W;

  // remainder unit: one dividend bit per cycle
  localparam int DIV_STEPS = RND_W;
  localparam int DCNT_W    = 5;

  typedef struct packed {
    logic       load;
    logic       add_commit;
    logic       div_init;
    logic       div_step;
    logic       walk_init;
    logic       walk_adv;
    logic       win_latch;
    logic       out_load;
    logic [2:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic draw;
    logic full;
    logic sum_zero;
    logic div_last;
    logic walk_end;
    logic fits;
  } sts_t;

endpackage

// File: src/lottery_scheduler_pick_unit.sv
// ----------------------------------------------------------------------------
// lottery_scheduler_pick_unit
// Lottery scheduler: stores ticket groups and draws a weighted winner.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel takes one item per handshake. in_tuser selects add (0) or
//   draw (1). An add stores (process_id, ticket_count) in the next free slot,
//   counts below 1 become one ticket; a full table answers status 1.
//   A draw reduces random_value modulo the ticket total and walks the table
//   in insertion order; an empty table answers status 2.
//   out_* channel returns exactly one result item per input item.
// Sequence:
//   add and empty draw: after accept the controller passes DECIDE and
//   DONE and loads the output register. draw: DECIDE, the one-bit-per-cycle
//   remainder unit, WINIT, then a WRD/WCMP pair for each of k = groups walked
//   (at most MAX_GROUPS) on the single table read port, then DONE.
//   One item is in work at a time; in_tready is high only while idle.
// Reset and stalls:
//   reset empties the table and clears the ticket total. A finished result
//   sits in the output register; a new item may be accepted meanwhile, and
//   its result waits until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module lottery_scheduler_pick_unit #(
  parameter int MAX_GROUPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // process_id[7:0], ticket_count[23:8],
                                  // random_value[54:24], zero pad[55]
  input  logic        in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // winner_id[7:0], total_tickets[26:8],
                                  // zero pad[31:27]
  output logic [2:0]  out_tuser   // winner_valid[0], status[2:1]
);

  lsp_pkg::cmd_t cmd;
  lsp_pkg::sts_t sts;

  logic [lsp_pkg::ID_W-1:0]  wid;
  logic                      wok;
  logic [1:0]                st;
  logic [lsp_pkg::TOT_W-1:0] tot;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsp_dp #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_kind(in_tuser),
    .in_pid (in_tdata[7:0]),
    .in_cnt (in_tdata[23:8]),
    .in_rnd (in_tdata[54:24]),
    .cmd    (cmd),
    .sts    (sts),
    .out_wid(wid),
    .out_wok(wok),
    .out_st (st),
    .out_tot(tot)
  );

  assign out_tdata = {5'd0, tot, wid};
  assign out_tuser = {st, wok};

endmodule

// File: src/lsp_dp.sv
// ----------------------------------------------------------------------------
// lsp_dp
// Datapath: group table, ticket sum, bit-serial remainder and table walk.
// ----------------------------------------------------------------------------
module lsp_dp #(
  parameter int MAX_GROUPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_kind,
  input  logic [lsp_pkg::ID_W-1:0]      in_pid,
  input  logic signed [lsp_pkg::CNT_W-1:0] in_cnt,
  input  logic [lsp_pkg::RND_W-1:0]     in_rnd,
  input  lsp_pkg::cmd_t                 cmd,
  output lsp_pkg::sts_t                 sts,
  output logic [lsp_pkg::ID_W-1:0]      out_wid,
  output logic                          out_wok,
  output logic [1:0]                    out_st,
  output logic [lsp_pkg::TOT_W-1:0]     out_tot
);

  localparam int SUM_W  = lsp_pkg::WGT_W + $clog2(MAX_GROUPS);
  localparam int FILL_W = $clog2(MAX_GROUPS + 1);
  localparam int IDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic                              kind_r;
  logic [lsp_pkg::ID_W-1:0]          pid_r;
  logic signed [lsp_pkg::CNT_W-1:0]  cnt_r;
  logic [lsp_pkg::RND_W-1:0]         rnd_r, rnd_nxt;
  logic [FILL_W-1:0]                 fill_r, fill_nxt;
  logic [SUM_W-1:0]                  sum_r, sum_nxt;
  logic [SUM_W-1:0]                  rem_r, rem_nxt;
  logic [lsp_pkg::DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic [SUM_W-1:0]                  left_r, left_nxt;
  logic [FILL_W-1:0]                 idx_r, idx_nxt;
  logic [lsp_pkg::ID_W-1:0]          win_r;
  logic [lsp_pkg::ENT_W-1:0]         rd_q_r;
  logic [lsp_pkg::ENT_W-1:0]         mem [MAX_GROUPS];

  logic [lsp_pkg::WGT_W-1:0]         wgt_clamp;
  logic [SUM_W:0]                    rem_shift;
  logic [SUM_W:0]                    rem_sub;
  logic [lsp_pkg::WGT_W-1:0]         rd_wgt;
  logic [lsp_pkg::ID_W-1:0]          rd_id;
  logic [SUM_W+lsp_pkg::TOT_W-1:0]   sum_ext;

  // counts of zero or below count as a single ticket
  assign wgt_clamp = (cnt_r < 16'sd1) ? lsp_pkg::WGT_W'(1) : cnt_r[lsp_pkg::WGT_W-1:0];

  assign rd_wgt = rd_q_r[lsp_pkg::WGT_W-1:0];
  assign rd_id  = rd_q_r[lsp_pkg::ENT_W-1:lsp_pkg::WGT_W];

  // restoring remainder step, rem stays below sum so the shift fits
  assign rem_shift = {rem_r, rnd_r[lsp_pkg::RND_W-1]};
  assign rem_sub   = rem_shift - {1'b0, sum_r};

  assign sts.draw     = kind_r;
  assign sts.full     = (fill_r == FILL_W'(MAX_GROUPS));
  assign sts.sum_zero = (sum_r == '0);
  assign sts.div_last = (dcnt_r == lsp_pkg::DCNT_W'(lsp_pkg::DIV_STEPS - 1));
  assign sts.walk_end = (idx_r == fill_r);
  assign sts.fits     = (left_r <= SUM_W'(rd_wgt));

  always_comb begin
    rnd_nxt  = rnd_r;
    rem_nxt  = rem_r;
    dcnt_nxt = dcnt_r;
    left_nxt = left_r;
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (cmd.add_commit) begin
      fill_nxt = fill_r + FILL_W'(1);
      sum_nxt  = sum_r + SUM_W'(wgt_clamp);
    end
    if (cmd.div_init) begin
      rnd_nxt  = rnd_r;
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end else if (cmd.div_step) begin
      rnd_nxt  = {rnd_r[lsp_pkg::RND_W-2:0], 1'b0};
      rem_nxt  = (rem_shift >= {1'b0, sum_r}) ? rem_sub[SUM_W-1:0] : rem_shift[SUM_W-1:0];
      dcnt_nxt = dcnt_r + lsp_pkg::DCNT_W'(1);
    end
    if (cmd.walk_init) begin
      left_nxt = rem_r + SUM_W'(1);
      idx_nxt  = '0;
    end else if (cmd.walk_adv) begin
      left_nxt = left_r - SUM_W'(rd_wgt);
      idx_nxt  = idx_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      pid_r  <= in_pid;
      cnt_r  <= in_cnt;
      rnd_r  <= in_rnd;
    end else begin
      rnd_r  <= rnd_nxt;
    end
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    left_r <= left_nxt;
    idx_r  <= idx_nxt;
    if (cmd.win_latch) begin
      win_r <= rd_id;
    end
  end

  // group table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      mem[fill_r[IDX_W-1:0]] <= {pid_r, wgt_clamp};
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[idx_r[IDX_W-1:0]];
  end

  assign sum_ext = {{lsp_pkg::TOT_W{1'b0}}, sum_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tot <= sum_ext[lsp_pkg::TOT_W-1:0];
      case (cmd.res_kind)
        lsp_pkg::RES_WIN: begin
          out_wid <= win_r;
          out_wok <= 1'b1;
          out_st  <= lsp_pkg::ST_OK;
        end
        lsp_pkg::RES_FULL: begin
          out_wid <= '0;
          out_wok <= 1'b0;
          out_st  <= lsp_pkg::ST_FULL;
        end
        lsp_pkg::RES_EMPTY: begin
          out_wid <= '0;
          out_wok <= 1'b0;
          out_st  <= lsp_pkg::ST_EMPTY;
        end
        default: begin
          out_wid <= '0;
          out_wok <= 1'b0;
          out_st  <= lsp_pkg::ST_OK;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_GROUPS))
    else $error("group fill beyond table depth");

  a_sum_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) == (sum_r == '0))
    else $error("ticket sum and fill disagree");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < sum_r))
    else $error("remainder not below ticket sum");
`endif

endmodule

// File: src/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl
// Controller: sequences add, remainder and table walk, owns the handshakes.
// ----------------------------------------------------------------------------
module lsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  lsp_pkg::sts_t sts,
  output lsp_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_WINIT  = 3'd3;
  localparam logic [2:0] S_WRD    = 3'd4;
  localparam logic [2:0] S_WCMP   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] res_r, res_nxt;
  logic       ovld_r, ovld_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt    = state_r;
    res_nxt      = res_r;
    cmd          = '0;
    cmd.res_kind = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.draw == lsp_pkg::KIND_ADD) begin
          if (sts.full) begin
            res_nxt = lsp_pkg::RES_FULL;
          end else begin
            cmd.add_commit = 1'b1;
            res_nxt        = lsp_pkg::RES_ADD;
          end
          state_nxt = S_DONE;
        end else if (sts.sum_zero) begin
          res_nxt   = lsp_pkg::RES_EMPTY;
          state_nxt = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_WINIT;
        end
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WRD;
      end
      S_WRD: begin
        // table read for the current index lands at this edge
        if (sts.walk_end) begin
          res_nxt   = lsp_pkg::RES_NONE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WCMP;
        end
      end
      S_WCMP: begin
        if (sts.fits) begin
          cmd.win_latch = 1'b1;
          res_nxt       = lsp_pkg::RES_WIN;
          state_nxt     = S_DONE;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WRD;
        end
      end
      S_DONE: begin
        if (!ovld_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= lsp_pkg::RES_ADD;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_tready) |-> !cmd.out_load)
    else $error("pending result overwritten");
`endif

endmodule
